// ===== src/slcd_pkg.sv =====
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; used by slcd_judge and the top level.
package slcd_pkg;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'hBB;

  // Minimum burst: two sync, two length, two checksum, two trailer bytes.
  localparam int unsigned MIN_BURST = 8;
  // Header bytes ahead of the payload minus one (sum covers bytes 2 .. L+3).
  localparam int unsigned SUM_LAST_OFS = 3;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_IDLE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_EMPTY = 2'd0,
    STATUS_VALID = 2'd1,
    STATUS_BAD   = 2'd2
  } status_t;

  // Burst bookkeeping handed from the byte path to the judge.
  typedef struct packed {
    logic            overflow_seen;
    logic            header_good;
    logic [15:0]     length_field;
    logic [15:0]     running_sum;
    logic [3:0][7:0] last_bytes;   // entry 0 newest
  } burst_info_t;

endpackage

// ===== src/slcd_judge.sv =====
// Burst verdict: classifies a closed burst as empty, valid or bad.
// Depends on slcd_pkg (burst_info_t, status_t, sync constants).
module slcd_judge #(
  parameter int unsigned CNT_W = 9
) (
  input  logic [CNT_W-1:0]      byte_count,
  input  slcd_pkg::burst_info_t info,
  output slcd_pkg::status_t     status,
  output logic [7:0]            payload_length
);

  logic [16:0] need_bytes;
  logic [16:0] have_bytes;
  logic [15:0] sent_sum;
  logic        short_burst;
  logic        trailer_ok;

  assign need_bytes  = 17'(info.length_field) + 17'(slcd_pkg::MIN_BURST);
  assign have_bytes  = 17'(byte_count);
  assign sent_sum    = {info.last_bytes[2], info.last_bytes[3]};
  assign short_burst = have_bytes < 17'(slcd_pkg::MIN_BURST);
  assign trailer_ok  = (info.last_bytes[1] == slcd_pkg::SYNC_B) &&
                       (info.last_bytes[0] == slcd_pkg::SYNC_A);

  always_comb begin
    status = slcd_pkg::STATUS_VALID;
    if (byte_count == '0 && !info.overflow_seen) begin
      status = slcd_pkg::STATUS_EMPTY;
    end else if (info.overflow_seen || short_burst || !info.header_good ||
                 !trailer_ok || (need_bytes > have_bytes) ||
                 (sent_sum != info.running_sum)) begin
      status = slcd_pkg::STATUS_BAD;
    end
    payload_length = (status == slcd_pkg::STATUS_VALID) ? info.length_field[7:0] : 8'd0;
  end

endmodule

// ===== src/sync_length_checksum_deframer_top.sv =====
// Sync/length/checksum deframer. Each request is either one received byte
// or a line-idle event that closes the burst. A good frame is AA BB, a
// 16-bit little-endian length L, L payload bytes, a 16-bit little-endian
// checksum (wrapping sum of the two length bytes and the payload), then
// BB AA. Byte requests update a running sum, a length register and a
// four-byte history in the cycle they are taken and produce no result.
// An idle request produces exactly one result in the next cycle: status
// empty (no bytes), valid (payload_length = low 8 bits of L) or bad
// (short burst, bad sync or trailer, length overrun, checksum mismatch,
// or more than MAX_FRAME bytes), and clears the burst state.
// Throughput is one request per clock while the input is not stalled; the
// result of an idle request is held in the single output register. The input
// stalls only while that output register holds a result that is stalled.
// Depends on slcd_pkg and slcd_judge.
module sync_length_checksum_deframer_top #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_payload_length
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  // burst state
  logic [CNT_W-1:0]      byte_count_r, byte_count_nxt;
  slcd_pkg::burst_info_t info_r, info_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] status_r;
  logic [7:0] len_r;

  logic                  take;
  logic                  take_byte;
  logic                  take_idle;
  slcd_pkg::status_t     judge_status;
  logic [7:0]            judge_len;
  logic [16:0]           idx_ext;
  logic [16:0]           sum_limit;

  // Only a stalled, full output register holds off new requests.
  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;
  assign take_byte = take && (slcd_pkg::mode_t'(in_mode) == slcd_pkg::MODE_BYTE);
  assign take_idle = take && (slcd_pkg::mode_t'(in_mode) == slcd_pkg::MODE_IDLE);

  assign idx_ext   = 17'(byte_count_r);
  assign sum_limit = 17'(info_r.length_field) + 17'(slcd_pkg::SUM_LAST_OFS);

  slcd_judge #(
    .CNT_W (CNT_W)
  ) u_judge (
    .byte_count     (byte_count_r),
    .info           (info_r),
    .status         (judge_status),
    .payload_length (judge_len)
  );

  // Byte path and end-of-burst clear.
  always_comb begin
    byte_count_nxt = byte_count_r;
    info_nxt       = info_r;
    if (take_idle) begin
      byte_count_nxt = '0;
      info_nxt       = '0;
    end else if (take_byte) begin
      if (idx_ext >= 17'(MAX_FRAME)) begin
        // burst too long: drop the byte, remember the overflow
        info_nxt.overflow_seen = 1'b1;
      end else begin
        if (idx_ext == 17'd1) begin
          info_nxt.header_good = (info_r.last_bytes[0] == slcd_pkg::SYNC_A) &&
                                 (in_rx_byte == slcd_pkg::SYNC_B);
        end
        if (idx_ext == 17'd2) begin
          info_nxt.length_field = {8'd0, in_rx_byte};
        end else if (idx_ext == 17'd3) begin
          info_nxt.length_field = {in_rx_byte, info_r.length_field[7:0]};
        end
        // sum covers the length bytes and the payload
        if (idx_ext >= 17'd2 && (idx_ext <= 17'd3 || idx_ext <= sum_limit)) begin
          info_nxt.running_sum = info_r.running_sum + 16'(in_rx_byte);
        end
        info_nxt.last_bytes = {info_r.last_bytes[2:0], in_rx_byte};
        byte_count_nxt      = byte_count_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take_idle) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      info_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      info_r       <= info_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload, loaded only when an idle request is taken
  always_ff @(posedge clk) begin
    if (take_idle) begin
      status_r <= judge_status;
      len_r    <= judge_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = status_r;
  assign out_payload_length = len_r;

endmodule
